// ===== rtl/sia_pkg.sv =====
// Shared types and codes for the small integer ALU.
// Operation codes, result kinds, unit classes and the item tag carried by the queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sia_pkg;

  localparam logic [3:0] CMD_ADD   = 4'd0;
  localparam logic [3:0] CMD_DIV   = 4'd1;
  localparam logic [3:0] CMD_MOD   = 4'd2;
  localparam logic [3:0] CMD_LESS  = 4'd3;
  localparam logic [3:0] CMD_EQUAL = 4'd4;
  localparam logic [3:0] CMD_MUL   = 4'd5;
  localparam logic [3:0] CMD_SUB   = 4'd6;
  localparam logic [3:0] CMD_OR    = 4'd7;
  localparam logic [3:0] CMD_AND   = 4'd8;
  localparam logic [3:0] CMD_SHIFT = 4'd9;

  localparam logic [1:0] KIND_INT   = 2'd0;
  localparam logic [1:0] KIND_TRUE  = 2'd1;
  localparam logic [1:0] KIND_FALSE = 2'd2;
  localparam logic [1:0] KIND_FAIL  = 2'd3;

  typedef logic [1:0] unit_t;

  // which part of the back end carries an item out
  localparam unit_t UNIT_ALU  = 2'd0;
  localparam unit_t UNIT_MUL  = 2'd1;
  localparam unit_t UNIT_DIV  = 2'd2;
  localparam unit_t UNIT_FAIL = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [3:0] cmd;
    unit_t      unit;
  } sia_tag_t;

  typedef struct packed {
    logic     push;
    sia_tag_t tag;
  } front_push_t;

  typedef struct packed {
    logic start;
    logic want_mod;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sia_front.sv =====
// Front end: takes items on the start/busy handshake and classifies them by unit.
// Depends on sia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sia_front import sia_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  start,
  input  logic [3:0]            cmd,
  input  logic [DATA_WIDTH-1:0] right_operand,
  input  logic                  q_full,
  output logic                  busy,
  output front_push_t           push_o
);

  unit_t unit;
  logic  div_zero;
  logic  div_minus_one;

  assign div_zero      = (right_operand == '0);
  assign div_minus_one = (right_operand == '1);

  always_comb begin
    case (cmd)
      CMD_ADD, CMD_SUB, CMD_LESS, CMD_EQUAL, CMD_OR, CMD_AND, CMD_SHIFT: begin
        unit = UNIT_ALU;
      end
      CMD_MUL: begin
        unit = UNIT_MUL;
      end
      CMD_DIV, CMD_MOD: begin
        // a zero divisor fails; minus one is a negate or zero, done in the ALU
        if (div_zero) begin
          unit = UNIT_FAIL;
        end else if (div_minus_one) begin
          unit = UNIT_ALU;
        end else begin
          unit = UNIT_DIV;
        end
      end
      default: begin
        unit = UNIT_FAIL;
      end
    endcase
  end

  assign busy            = q_full;
  assign push_o.push     = start && !q_full;
  assign push_o.tag.cmd  = cmd;
  assign push_o.tag.unit = unit;

endmodule

`default_nettype wire

// ===== rtl/sia_queue.sv =====
// Short item queue between front and back end.
// Holds tag and both operands; depth from sia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sia_queue import sia_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  front_push_t           push_i,
  input  logic [DATA_WIDTH-1:0] push_left,
  input  logic [DATA_WIDTH-1:0] push_right,
  input  logic                  pop,
  output logic                  q_valid,
  output logic                  q_full,
  output sia_tag_t              head_tag,
  output logic [DATA_WIDTH-1:0] head_left,
  output logic [DATA_WIDTH-1:0] head_right
);

  sia_tag_t              tag_mem   [QDEPTH];
  logic [DATA_WIDTH-1:0] left_mem  [QDEPTH];
  logic [DATA_WIDTH-1:0] right_mem [QDEPTH];

  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  logic do_push;
  logic do_pop;

  assign do_push = push_i.push && !q_full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(do_push);
    rd_ptr_nxt = rd_ptr_r + QAW'(do_pop);
    count_nxt  = count_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      tag_mem[wr_ptr_r]   <= push_i.tag;
      left_mem[wr_ptr_r]  <= push_left;
      right_mem[wr_ptr_r] <= push_right;
    end
  end

  assign q_valid    = (count_r != '0);
  assign q_full     = (count_r == (QAW+1)'(QDEPTH));
  assign head_tag   = tag_mem[rd_ptr_r];
  assign head_left  = left_mem[rd_ptr_r];
  assign head_right = right_mem[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/sia_div.sv =====
// Signed divider, one quotient bit per cycle (restoring, on magnitudes).
// Truncating quotient, remainder signed as the dividend. Depends on sia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sia_div import sia_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  div_ctrl_t             ctrl_i,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output div_stat_t             stat_o,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int CW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] den_r, den_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  neg_q_r, neg_q_nxt;
  logic                  neg_r_r, neg_r_nxt;
  logic                  mod_r, mod_nxt;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   trial;
  logic                  fits;

  assign shifted = {rem_r, quo_r[DATA_WIDTH-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = !trial[DATA_WIDTH];

  always_comb begin
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    mod_nxt   = mod_r;
    if (ctrl_i.start) begin
      rem_nxt   = '0;
      quo_nxt   = dividend[DATA_WIDTH-1] ? ('0 - dividend) : dividend;
      den_nxt   = divisor[DATA_WIDTH-1] ? ('0 - divisor) : divisor;
      cnt_nxt   = CW'(DATA_WIDTH-1);
      busy_nxt  = 1'b1;
      neg_q_nxt = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      neg_r_nxt = dividend[DATA_WIDTH-1];
      mod_nxt   = ctrl_i.want_mod;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo_nxt = {quo_r[DATA_WIDTH-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    den_r   <= den_nxt;
    cnt_r   <= cnt_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
    mod_r   <= mod_nxt;
  end

  // most negative over one lands on 2^(W-1) unsigned, which is the wrapped value
  always_comb begin
    if (mod_r) begin
      result = neg_r_r ? ('0 - rem_r) : rem_r;
    end else begin
      result = neg_q_r ? ('0 - quo_r) : quo_r;
    end
  end

  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;

endmodule

`default_nettype wire

// ===== rtl/sia_back.sv =====
// Back end: issues queued items in order into a two-stage pipeline.
// Stage 1 does ALU work and partial products, stage 2 sums products and drives the result.
// Depends on sia_pkg and sia_div.
`timescale 1ns / 1ps
`default_nettype none

module sia_back import sia_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  sia_tag_t              head_tag,
  input  logic [DATA_WIDTH-1:0] head_left,
  input  logic [DATA_WIDTH-1:0] head_right,
  output logic                  pop,
  output logic                  out_valid,
  output logic [1:0]            out_result_kind,
  output logic [DATA_WIDTH-1:0] out_result_value
);

  localparam int SW = $clog2(DATA_WIDTH);
  localparam int HW = (DATA_WIDTH + 1) / 2;   // low half of each multiplier operand
  localparam int LW = DATA_WIDTH - HW;        // high half

  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  logic [DATA_WIDTH-1:0] div_result;

  logic                  issue;
  logic [1:0]            alu_kind;
  logic [DATA_WIDTH-1:0] alu_val;
  logic [DATA_WIDTH-1:0] l;
  logic [DATA_WIDTH-1:0] r;
  logic [DATA_WIDTH-1:0] sh_mag;
  logic [DATA_WIDTH-1:0] sh_res;

  logic [2*HW-1:0]       p_lo;
  logic [LW-1:0]         p_cross;

  logic                  s1_vld_r, s1_vld_nxt;
  logic                  s1_mul_r, s1_mul_nxt;
  logic [1:0]            s1_kind_r, s1_kind_nxt;
  logic [DATA_WIDTH-1:0] s1_val_r, s1_val_nxt;
  logic [DATA_WIDTH-1:0] mul_lo_r;
  logic [LW-1:0]         mul_hi_r;

  logic                  out_vld_r;
  logic [1:0]            out_kind_r;
  logic [DATA_WIDTH-1:0] out_val_r, out_val_nxt;

  // the divider owns stage 1 for the cycle its result comes out
  assign issue = q_valid && !div_stat.busy && !div_stat.done;
  assign pop   = issue;

  assign l = head_left;
  assign r = head_right;

  assign div_ctrl.start    = issue && (head_tag.unit == UNIT_DIV);
  assign div_ctrl.want_mod = (head_tag.cmd == CMD_MOD);

  sia_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl_i  (div_ctrl),
    .dividend(l),
    .divisor (r),
    .stat_o  (div_stat),
    .result  (div_result)
  );

  assign sh_mag = '0 - r;

  always_comb begin
    alu_kind = KIND_INT;
    alu_val  = '0;
    sh_res   = '0;
    case (head_tag.cmd)
      CMD_ADD:   alu_val = l + r;
      CMD_SUB:   alu_val = l - r;
      CMD_OR:    alu_val = l | r;
      CMD_AND:   alu_val = l & r;
      CMD_MUL:   alu_val = '0;   // product is summed in stage 2
      CMD_LESS:  alu_kind = ($signed(l) < $signed(r)) ? KIND_TRUE : KIND_FALSE;
      CMD_EQUAL: alu_kind = (l == r) ? KIND_TRUE : KIND_FALSE;
      CMD_DIV:   alu_val = '0 - l;   // divisor of minus one
      CMD_MOD:   alu_val = '0;
      CMD_SHIFT: begin
        if (r[DATA_WIDTH-1]) begin
          if (sh_mag >= DATA_WIDTH'(DATA_WIDTH-1)) begin
            alu_val = {DATA_WIDTH{l[DATA_WIDTH-1]}};
          end else begin
            alu_val = DATA_WIDTH'($signed(l) >>> sh_mag[SW-1:0]);
          end
        end else begin
          if (r < DATA_WIDTH'(DATA_WIDTH)) begin
            sh_res = l << r[SW-1:0];
          end
          // bits lost off the top show up as a result below the operand
          if ($signed(sh_res) < $signed(l)) begin
            alu_kind = KIND_FAIL;
          end else begin
            alu_val = sh_res;
          end
        end
      end
      default: alu_kind = KIND_FAIL;
    endcase
    if (head_tag.unit == UNIT_FAIL) begin
      alu_kind = KIND_FAIL;
    end
    if (alu_kind != KIND_INT) begin
      alu_val = '0;
    end
  end

  // low product split into halves so no multiplier exceeds half the word
  assign p_lo    = (2*HW)'(l[HW-1:0]) * (2*HW)'(r[HW-1:0]);
  assign p_cross = LW'(l[DATA_WIDTH-1:HW] * r[LW-1:0]) + LW'(l[LW-1:0] * r[DATA_WIDTH-1:HW]);

  always_comb begin
    s1_vld_nxt  = 1'b0;
    s1_mul_nxt  = 1'b0;
    s1_kind_nxt = KIND_INT;
    s1_val_nxt  = '0;
    if (div_stat.done) begin
      s1_vld_nxt = 1'b1;
      s1_val_nxt = div_result;
    end else if (issue && (head_tag.unit != UNIT_DIV)) begin
      s1_vld_nxt  = 1'b1;
      s1_mul_nxt  = (head_tag.unit == UNIT_MUL);
      s1_kind_nxt = alu_kind;
      s1_val_nxt  = alu_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_mul_r   <= s1_mul_nxt;
    s1_kind_r  <= s1_kind_nxt;
    s1_val_r   <= s1_val_nxt;
    mul_lo_r   <= p_lo[DATA_WIDTH-1:0];
    mul_hi_r   <= p_cross;
    out_kind_r <= s1_kind_r;
    out_val_r  <= out_val_nxt;
  end

  always_comb begin
    if (s1_mul_r) begin
      out_val_nxt = mul_lo_r + {mul_hi_r, {HW{1'b0}}};
    end else begin
      out_val_nxt = s1_val_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_value = out_val_r;

endmodule

`default_nettype wire

// ===== rtl/small_integer_alu.sv =====
// Small integer ALU: add, sub, mul, div, mod, compare, logic and signed shift.
// Path: an accepted item passes through the queue, the stage 1 register and the output register;
// items for the divider pass through it before stage 1 (it retires one quotient bit per cycle).
// Throughput: one item per cycle; an item for the divider holds issue until its result enters stage 1,
// while the 4-entry queue keeps taking items until full. No result back-pressure.
// Reset: synchronous, active low; empties the queue, the divider and the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module small_integer_alu import sia_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   in_cmd,
  input  logic signed [DATA_WIDTH-1:0] in_left_operand,
  input  logic signed [DATA_WIDTH-1:0] in_right_operand,
  output logic                         out_valid,
  output logic [1:0]                   out_result_kind,
  output logic signed [DATA_WIDTH-1:0] out_result_value
);

  front_push_t           push;
  logic                  q_full;
  logic                  q_valid;
  logic                  pop;
  sia_tag_t              head_tag;
  logic [DATA_WIDTH-1:0] head_left;
  logic [DATA_WIDTH-1:0] head_right;
  logic [DATA_WIDTH-1:0] res_value;

  sia_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .start        (start),
    .cmd          (in_cmd),
    .right_operand(in_right_operand),
    .q_full       (q_full),
    .busy         (busy),
    .push_o       (push)
  );

  sia_queue #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .push_left (in_left_operand),
    .push_right(in_right_operand),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head_tag  (head_tag),
    .head_left (head_left),
    .head_right(head_right)
  );

  sia_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .head_tag        (head_tag),
    .head_left       (head_left),
    .head_right      (head_right),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_result_value(res_value)
  );

  assign out_result_value = $signed(res_value);

endmodule

`default_nettype wire

// ===== rtl/sia_checker.sv =====
// Port-level checks for the small integer ALU, bound to the top level.
// Depends on sia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sia_checker import sia_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [1:0]            out_result_kind,
  input logic [DATA_WIDTH-1:0] out_result_value
);

  // anything but an integer carries a zero value
  a_nonint_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != KIND_INT) |-> (out_result_value == '0))
    else $error("non-integer result with non-zero value");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_rst_busy: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy right after reset");

  // the queue can only fill through an item taken on the edge before
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

endmodule

bind small_integer_alu sia_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_sia_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_result_kind (out_result_kind),
  .out_result_value(out_result_value)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for small_integer_alu: directed corner items, then random items.
// Each item's expected kind and value are worked out here, and results are checked in order.
// Depends on sia_pkg and the small_integer_alu RTL.
`timescale 1ns / 1ps

module tb_top;
  import sia_pkg::*;

  localparam int DW         = 32;
  localparam int N_RANDOM   = 1000;
  localparam int CALM_TAIL  = 150;
  localparam int LIMIT      = 400000;
  localparam logic [3:0] CMD_SPARE_LO = CMD_SHIFT + 4'd1;
  localparam logic [3:0] CMD_SPARE_HI = 4'hF;

  localparam logic signed [DW-1:0] MIN_S = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MAX_S = {1'b0, {(DW-1){1'b1}}};

  typedef struct {
    logic [3:0]           cmd;
    logic signed [DW-1:0] lhs;
    logic signed [DW-1:0] rhs;
    int                   gap;    // idle cycles before the item is offered
    bit                   drain;  // hold back until every result is in
  } alu_op_t;

  typedef struct {
    logic [1:0]           kind;
    logic signed [DW-1:0] value;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [3:0] in_cmd = '0;
  logic signed [DW-1:0] in_left_operand = '0;
  logic signed [DW-1:0] in_right_operand = '0;
  logic busy;
  logic out_valid;
  logic [1:0] out_result_kind;
  logic signed [DW-1:0] out_result_value;

  alu_op_t  op_queue[$];
  alu_res_t result_q[$];
  int errors = 0;
  int cycles = 0;

  small_integer_alu #(.DATA_WIDTH(DW)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_left_operand  (in_left_operand),
    .in_right_operand (in_right_operand),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_result_value (out_result_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic alu_res_t alu_eval(alu_op_t op);
    alu_res_t             res;
    logic signed [DW-1:0] l;
    logic signed [DW-1:0] r;
    logic [DW-1:0]        mag;
    logic signed [DW-1:0] shl;
    l = op.lhs;
    r = op.rhs;
    res.kind = KIND_INT;
    res.value = '0;
    case (op.cmd)
      CMD_ADD: res.value = l + r;
      CMD_SUB: res.value = l - r;
      CMD_MUL: res.value = l * r;
      CMD_OR:  res.value = l | r;
      CMD_AND: res.value = l & r;
      CMD_DIV, CMD_MOD: begin
        if (r == 0) begin
          res.kind = KIND_FAIL;
        end else if (r == -1) begin
          // covers most negative over minus one without overflow
          res.value = (op.cmd == CMD_DIV) ? -l : '0;
        end else begin
          res.value = (op.cmd == CMD_DIV) ? l / r : l % r;
        end
      end
      CMD_LESS:  res.kind = (l < r) ? KIND_TRUE : KIND_FALSE;
      CMD_EQUAL: res.kind = (l == r) ? KIND_TRUE : KIND_FALSE;
      CMD_SHIFT: begin
        if (r[DW-1]) begin
          mag = '0 - r;
          if (mag >= DW - 1) res.value = l[DW-1] ? '1 : '0;
          else res.value = l >>> mag;
        end else begin
          shl = (r < DW) ? (l << r) : '0;
          if (shl < l) res.kind = KIND_FAIL;
          else res.value = shl;
        end
      end
      default: res.kind = KIND_FAIL;
    endcase
    if (res.kind != KIND_INT) res.value = '0;
    return res;
  endfunction

  task automatic queue_op(logic [3:0] cmd, logic signed [DW-1:0] lhs,
                          logic signed [DW-1:0] rhs, int gap, bit drain);
    alu_op_t op;
    op.cmd = cmd;
    op.lhs = lhs;
    op.rhs = rhs;
    op.gap = gap;
    op.drain = drain;
    op_queue.push_back(op);
  endtask

  function automatic logic signed [DW-1:0] rand_operand();
    logic signed [DW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = MIN_S;
      1: v = MAX_S;
      2: v = $signed($urandom_range(0, 4)) - 2;
      3: v = $signed($urandom_range(0, 200)) - 100;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
    $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
    errors++;
  endtask

  // driver: offers the front of op_queue, records the expectation on acceptance
  always @(posedge clk) begin : driver
    int idle_left;
    bit gap_loaded;
    if (!rst_n) begin
      start <= 1'b0;
      gap_loaded = 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        result_q.push_back(alu_eval(op_queue[0]));
        op_queue.pop_front();
        gap_loaded = 1'b0;
      end
      if (!(start && busy)) begin
        if (op_queue.size() == 0) begin
          start <= 1'b0;
        end else begin
          if (!gap_loaded) begin
            idle_left = op_queue[0].gap;
            gap_loaded = 1'b1;
          end
          if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
          end else if (op_queue[0].drain && result_q.size() != 0) begin
            start <= 1'b0;
          end else begin
            start <= 1'b1;
            in_cmd <= op_queue[0].cmd;
            in_left_operand <= op_queue[0].lhs;
            in_right_operand <= op_queue[0].rhs;
          end
        end
      end
    end
  end

  // monitor: results come one cycle each and cannot be held off
  always @(posedge clk) begin : monitor
    alu_res_t want;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result", {{(DW-2){1'b0}}, out_result_kind},
                        out_result_value);
      end else begin
        want = result_q.pop_front();
        if (out_result_kind !== want.kind)
          report_mismatch("result_kind", {{(DW-2){1'b0}}, out_result_kind},
                          {{(DW-2){1'b0}}, want.kind});
        if (out_result_value !== want.value)
          report_mismatch("result_value", out_result_value, want.value);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("small_integer_alu: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [3:0]           cmd;
    logic signed [DW-1:0] lhs;
    logic signed [DW-1:0] rhs;
    int                   gap;
    int                   pick;
    // directed corners
    queue_op(CMD_ADD,   MAX_S, 1, 0, 1'b0);
    queue_op(CMD_SUB,   MIN_S, 1, 0, 1'b0);
    queue_op(CMD_MUL,   MAX_S, MAX_S, 0, 1'b0);
    queue_op(CMD_MUL,   MIN_S, -1, 0, 1'b0);
    queue_op(CMD_DIV,   7, -2, 0, 1'b0);
    queue_op(CMD_DIV,   MAX_S, 0, 0, 1'b0);
    queue_op(CMD_DIV,   MIN_S, -1, 0, 1'b0);
    queue_op(CMD_MOD,   -7, 2, 0, 1'b0);
    queue_op(CMD_MOD,   MIN_S, 0, 0, 1'b0);
    queue_op(CMD_MOD,   MIN_S, -1, 0, 1'b0);
    queue_op(CMD_MOD,   12345, 12345, 0, 1'b0);
    queue_op(CMD_LESS,  MIN_S, MAX_S, 0, 1'b0);
    queue_op(CMD_LESS,  MAX_S, MIN_S, 0, 1'b0);
    queue_op(CMD_EQUAL, -1, -1, 0, 1'b0);
    queue_op(CMD_EQUAL, MIN_S, MAX_S, 0, 1'b0);
    queue_op(CMD_OR,    MIN_S, MAX_S, 0, 1'b0);
    queue_op(CMD_AND,   -1, 32'h5a5a_a5a5, 0, 1'b0);
    queue_op(CMD_SHIFT, 1, DW - 1, 0, 1'b0);   // sign bit lands: left > result
    queue_op(CMD_SHIFT, 1, DW - 2, 0, 1'b0);
    queue_op(CMD_SHIFT, 5, DW + 8, 0, 1'b0);   // zero result below a positive left
    queue_op(CMD_SHIFT, -5, DW, 0, 1'b0);
    queue_op(CMD_SHIFT, MIN_S, -(DW - 1), 0, 1'b0);
    queue_op(CMD_SHIFT, MAX_S, MIN_S, 0, 1'b0);
    queue_op(CMD_SHIFT, MIN_S, -(DW - 2), 0, 1'b0);
    queue_op(CMD_SPARE_HI, -1, -1, 0, 1'b0);

    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 31);
      if (pick < 30) cmd = 4'(pick % 10);
      else cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      lhs = rand_operand();
      rhs = rand_operand();
      if (cmd == CMD_SHIFT && $urandom_range(0, 3) != 0)
        rhs = $signed($urandom_range(0, 2 * DW + 16)) - (DW + 8);
      if ((cmd == CMD_DIV || cmd == CMD_MOD) && $urandom_range(0, 9) == 0)
        rhs = lhs;
      gap = 0;
      // quiet stretches every so often, and none at all near the end
      if (i < N_RANDOM - CALM_TAIL && (i % 200) >= 50 && $urandom_range(0, 4) == 0)
        gap = $urandom_range(1, 9);
      queue_op(cmd, lhs, rhs, gap, (i == 0 || i == 300 || i == 700));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || result_q.size() != 0) @(negedge clk);
    repeat (DW + 8) @(negedge clk);
    if (errors == 0) begin
      $display("small_integer_alu: match");
    end else begin
      $display("small_integer_alu: mismatch");
    end
    $finish;
  end

endmodule
